FILE: hw/rtl/amstep_pkg.sv
package amstep_pkg;

  localparam int WORD_W        = 16;
  localparam int PC_W          = 7;
  localparam int OPC_W         = 9;
  localparam int MEM_WORDS_DEF = 100;
  localparam int WORD_LIMIT    = 9999;
  localparam int DIV_CNT_W     = $clog2(WORD_W);

  // truncating divide by 100 as multiply and shift, exact below 43690
  localparam int DECIMAL_BASE  = 100;
  localparam int DIV100_MUL    = 5243;
  localparam int DIV100_SHIFT  = 19;
  localparam int DEC_PROD_W    = WORD_W + 13;

  typedef logic [1:0] operation_t;
  localparam operation_t OP_APPEND = 2'd0;
  localparam operation_t OP_START  = 2'd1;
  localparam operation_t OP_STEP   = 2'd2;
  localparam operation_t OP_CLEAR  = 2'd3;

  typedef logic [2:0] status_t;
  localparam status_t ST_RUN     = 3'd0;
  localparam status_t ST_HALT    = 3'd1;
  localparam status_t ST_ADDR    = 3'd2;
  localparam status_t ST_DIV0    = 3'd3;
  localparam status_t ST_OVF     = 3'd4;
  localparam status_t ST_INRANGE = 3'd5;
  localparam status_t ST_FULL    = 3'd6;

  typedef logic [OPC_W-1:0] opcode_t;
  localparam opcode_t OPC_READ   = 9'd10;
  localparam opcode_t OPC_WRITE  = 9'd11;
  localparam opcode_t OPC_LOAD   = 9'd20;
  localparam opcode_t OPC_STORE  = 9'd21;
  localparam opcode_t OPC_ADD    = 9'd30;
  localparam opcode_t OPC_SUB    = 9'd31;
  localparam opcode_t OPC_DIV    = 9'd32;
  localparam opcode_t OPC_MUL    = 9'd33;
  localparam opcode_t OPC_BR     = 9'd40;
  localparam opcode_t OPC_BRNEG  = 9'd41;
  localparam opcode_t OPC_BRZERO = 9'd42;
  localparam opcode_t OPC_HALT   = 9'd43;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [2*WORD_W-1:0] wide_t;

  typedef struct packed {
    operation_t operation;
    word_t      data_value;
  } item_t;

  typedef struct packed {
    status_t         status;
    logic [PC_W-1:0] program_counter;
    word_t           accumulator_value;
    logic            print_valid;
    word_t           printed_word;
    logic            input_used;
  } result_t;

  function automatic logic in_word_range(input wide_t v);
    wide_t lim;
    lim = wide_t'(WORD_LIMIT);
    return (v <= lim) && (v >= -lim);
  endfunction

endpackage

FILE: hw/rtl/amstep_chan_if.sv
interface amstep_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/accumulator_machine_step.sv
// sequencing: append, start, clear and a step that stops at once go straight from idle to
//   the output state; an executed step passes fetch, operand read and execute, a divide
//   then the radix-2 divider and its end state; the result register loads in the output
//   state once the output is free; one beat at a time, no new beat is taken until then;
//   fetch, decode, operand read and execute share one memory port
// reset (rst, synchronous): count, pc and accumulator cleared, halted, memory undefined
module accumulator_machine_step #(
  parameter int MEM_WORDS = amstep_pkg::MEM_WORDS_DEF
) (
  input logic           clk,
  input logic           rst,
  amstep_chan_if.sink   item,
  amstep_chan_if.source result
);
  import amstep_pkg::*;

  localparam int ADDR_W = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FETCH = 7'b0000010,
    S_OPER  = 7'b0000100,
    S_EXEC  = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_DEND  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state, state_next;

  word_t mem [MEM_WORDS];
  word_t rdata;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  word_t             mem_wdata;

  logic [PC_W-1:0] pc, pc_next;
  logic [PC_W-1:0] count, count_next;
  word_t           acc, acc_next;
  status_t         run_st, run_st_next;

  status_t res_status, res_status_next;
  logic    res_pv, res_pv_next;
  word_t   res_pval, res_pval_next;
  logic    res_used, res_used_next;

  word_t                 cur_data, cur_data_next;
  logic [WORD_W-2:0]     word_q, word_q_next;
  opcode_t               op_q, op_q_next;
  logic [PC_W-1:0]       opnd_a, opnd_a_next;

  logic [WORD_W-1:0]    dq, dq_next;
  logic [WORD_W-1:0]    dvs, dvs_next;
  logic [WORD_W-1:0]    rem, rem_next;
  logic [DIV_CNT_W-1:0] dcnt, dcnt_next;
  logic                 dneg, dneg_next;

  logic    out_valid;
  result_t out_data;

  logic                  accept;
  logic [DEC_PROD_W-1:0] dec_prod;
  logic [WORD_W-1:0]     a_full;
  logic                  addr_ok;
  logic signed [WORD_W:0] sum_v, dif_v;
  wide_t                 prod_v;
  logic [WORD_W:0]       rem_sh;
  logic                  load_out;

  assign accept     = item.valid && item.ready;
  assign item.ready = (state == S_IDLE);

  assign dec_prod = DEC_PROD_W'(rdata[WORD_W-2:0]) * DEC_PROD_W'(DIV100_MUL);
  assign a_full   = {1'b0, word_q} - WORD_W'(op_q * DECIMAL_BASE);
  assign addr_ok  = opnd_a < count;
  assign sum_v    = {acc[WORD_W-1], acc} + {rdata[WORD_W-1], rdata};
  assign dif_v    = {acc[WORD_W-1], acc} - {rdata[WORD_W-1], rdata};
  assign prod_v   = acc * rdata;
  assign rem_sh   = {rem, dq[WORD_W-1]};
  assign load_out = (state == S_OUT) && (!out_valid || result.ready);

  always_comb begin
    logic    fault;
    logic    advance;
    logic    go_div;
    status_t fcode;
    fault   = 1'b0;
    advance = 1'b0;
    go_div  = 1'b0;
    fcode   = ST_RUN;

    state_next      = state;
    pc_next         = pc;
    count_next      = count;
    acc_next        = acc;
    run_st_next     = run_st;
    res_status_next = res_status;
    res_pv_next     = res_pv;
    res_pval_next   = res_pval;
    res_used_next   = res_used;
    cur_data_next   = cur_data;
    word_q_next     = word_q;
    op_q_next       = op_q;
    opnd_a_next     = opnd_a;
    dq_next         = dq;
    dvs_next        = dvs;
    rem_next        = rem;
    dcnt_next       = dcnt;
    dneg_next       = dneg;

    mem_we    = 1'b0;
    mem_waddr = count[ADDR_W-1:0];
    mem_wdata = item.data.data_value;
    mem_re    = 1'b0;
    mem_raddr = pc[ADDR_W-1:0];

    case (state)
      S_IDLE: begin
        if (accept) begin
          cur_data_next = item.data.data_value;
          res_pv_next   = 1'b0;
          res_pval_next = '0;
          res_used_next = 1'b0;
          state_next    = S_OUT;
          case (item.data.operation)
            OP_APPEND: begin
              if (count == PC_W'(MEM_WORDS)) begin
                res_status_next = ST_FULL;
              end else begin
                mem_we          = 1'b1;
                count_next      = count + 1'b1;
                res_status_next = ST_RUN;
              end
            end
            OP_START: begin
              pc_next         = '0;
              acc_next        = '0;
              run_st_next     = ST_RUN;
              res_status_next = ST_RUN;
            end
            OP_STEP: begin
              if (run_st != ST_RUN) begin
                res_status_next = run_st;
              end else if (pc >= count) begin
                run_st_next     = ST_ADDR;
                res_status_next = ST_ADDR;
              end else begin
                mem_re     = 1'b1;
                state_next = S_FETCH;
              end
            end
            default: begin
              count_next      = '0;
              pc_next         = '0;
              acc_next        = '0;
              run_st_next     = ST_HALT;
              res_status_next = ST_HALT;
            end
          endcase
        end
      end
      S_FETCH: begin
        // negative words decode to no known opcode
        word_q_next = rdata[WORD_W-2:0];
        op_q_next   = rdata[WORD_W-1] ? '0 : dec_prod[DIV100_SHIFT +: OPC_W];
        state_next  = S_OPER;
      end
      S_OPER: begin
        opnd_a_next = a_full[PC_W-1:0];
        mem_raddr   = a_full[ADDR_W-1:0];
        mem_re      = (a_full[PC_W-1:0] < count);
        state_next  = S_EXEC;
      end
      S_EXEC: begin
        advance   = 1'b1;
        mem_waddr = opnd_a[ADDR_W-1:0];
        mem_wdata = acc;
        case (op_q)
          OPC_READ: begin
            res_used_next = 1'b1;
            if (!in_word_range(wide_t'(cur_data))) begin
              fault = 1'b1;
              fcode = ST_INRANGE;
            end else if (!addr_ok) begin
              fault = 1'b1;
              fcode = ST_ADDR;
            end else begin
              mem_we    = 1'b1;
              mem_wdata = cur_data;
            end
          end
          OPC_WRITE: begin
            if (!addr_ok) begin
              fault = 1'b1;
              fcode = ST_ADDR;
            end else begin
              res_pv_next   = 1'b1;
              res_pval_next = rdata;
            end
          end
          OPC_LOAD: begin
            if (!addr_ok) begin
              fault = 1'b1;
              fcode = ST_ADDR;
            end else begin
              acc_next = rdata;
            end
          end
          OPC_STORE: begin
            if (!addr_ok) begin
              fault = 1'b1;
              fcode = ST_ADDR;
            end else begin
              mem_we = 1'b1;
            end
          end
          OPC_ADD: begin
            if (!addr_ok) begin
              fault = 1'b1;
              fcode = ST_ADDR;
            end else if (!in_word_range(wide_t'(sum_v))) begin
              fault = 1'b1;
              fcode = ST_OVF;
            end else begin
              acc_next = sum_v[WORD_W-1:0];
            end
          end
          OPC_SUB: begin
            if (!addr_ok) begin
              fault = 1'b1;
              fcode = ST_ADDR;
            end else if (!in_word_range(wide_t'(dif_v))) begin
              fault = 1'b1;
              fcode = ST_OVF;
            end else begin
              acc_next = dif_v[WORD_W-1:0];
            end
          end
          OPC_MUL: begin
            if (!addr_ok) begin
              fault = 1'b1;
              fcode = ST_ADDR;
            end else if (!in_word_range(prod_v)) begin
              fault = 1'b1;
              fcode = ST_OVF;
            end else begin
              acc_next = prod_v[WORD_W-1:0];
            end
          end
          OPC_DIV: begin
            if (!addr_ok) begin
              fault = 1'b1;
              fcode = ST_ADDR;
            end else if (rdata == '0) begin
              fault = 1'b1;
              fcode = ST_DIV0;
            end else begin
              go_div    = 1'b1;
              advance   = 1'b0;
              dq_next   = acc[WORD_W-1] ? WORD_W'(-acc) : WORD_W'(acc);
              dvs_next  = rdata[WORD_W-1] ? WORD_W'(-rdata) : WORD_W'(rdata);
              rem_next  = '0;
              dcnt_next = '0;
              dneg_next = acc[WORD_W-1] ^ rdata[WORD_W-1];
            end
          end
          OPC_BR, OPC_BRNEG, OPC_BRZERO: begin
            if ((op_q == OPC_BR) || (op_q == OPC_BRNEG && acc[WORD_W-1]) ||
                (op_q == OPC_BRZERO && acc == '0)) begin
              if (!addr_ok) begin
                fault = 1'b1;
                fcode = ST_ADDR;
              end else begin
                pc_next = opnd_a;
                advance = 1'b0;
              end
            end
          end
          OPC_HALT: begin
            run_st_next = ST_HALT;
          end
          default: begin
          end
        endcase
        if (fault) begin
          advance         = 1'b0;
          run_st_next     = fcode;
          res_status_next = fcode;
        end else begin
          res_status_next = run_st_next;
        end
        if (advance) begin
          pc_next = pc + 1'b1;
        end
        state_next = go_div ? S_DIV : S_OUT;
      end
      S_DIV: begin
        if (rem_sh >= {1'b0, dvs}) begin
          rem_next = WORD_W'(rem_sh - {1'b0, dvs});
          dq_next  = {dq[WORD_W-2:0], 1'b1};
        end else begin
          rem_next = rem_sh[WORD_W-1:0];
          dq_next  = {dq[WORD_W-2:0], 1'b0};
        end
        dcnt_next = dcnt + 1'b1;
        if (dcnt == DIV_CNT_W'(WORD_W - 1)) begin
          state_next = S_DEND;
        end
      end
      S_DEND: begin
        if (dq > WORD_W'(WORD_LIMIT)) begin
          run_st_next     = ST_OVF;
          res_status_next = ST_OVF;
        end else begin
          acc_next        = dneg ? -word_t'(dq) : word_t'(dq);
          pc_next         = pc + 1'b1;
          res_status_next = ST_RUN;
        end
        state_next = S_OUT;
      end
      S_OUT: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      pc     <= '0;
      count  <= '0;
      acc    <= '0;
      run_st <= ST_HALT;
    end else begin
      state  <= state_next;
      pc     <= pc_next;
      count  <= count_next;
      acc    <= acc_next;
      run_st <= run_st_next;
    end
  end

  always_ff @(posedge clk) begin
    res_status <= res_status_next;
    res_pv     <= res_pv_next;
    res_pval   <= res_pval_next;
    res_used   <= res_used_next;
    cur_data   <= cur_data_next;
    word_q     <= word_q_next;
    op_q       <= op_q_next;
    opnd_a     <= opnd_a_next;
    dq         <= dq_next;
    dvs        <= dvs_next;
    rem        <= rem_next;
    dcnt       <= dcnt_next;
    dneg       <= dneg_next;
  end

  // program memory, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  // result register, parts the beat on the output from the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data.status            <= res_status;
      out_data.program_counter   <= pc;
      out_data.accumulator_value <= acc;
      out_data.print_valid       <= res_pv;
      out_data.printed_word      <= res_pval;
      out_data.input_used        <= res_used;
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_data;

`ifndef SYNTHESIS
  a_bounds: assert property (@(posedge clk) disable iff (rst)
    (count <= PC_W'(MEM_WORDS)) && (pc <= PC_W'(MEM_WORDS)))
    else $error("loaded count or pc beyond memory");

  a_one_beat: assert property (@(posedge clk) disable iff (rst)
    accept |=> !item.ready)
    else $error("new beat taken while one is in flight");

  a_fetch_ok: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH) |-> (run_st == ST_RUN) && (pc < count))
    else $error("fetch issued while stopped or out of range");

  a_div_entry: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> ($past(state) == S_EXEC) || ($past(state) == S_DIV))
    else $error("divider entered out of sequence");
`endif

endmodule

FILE: sim/accumulator_machine_step_tb.sv
module accumulator_machine_step_tb;
  import amstep_pkg::*;

  localparam int MEM_WORDS   = MEM_WORDS_DEF;
  localparam int CYCLE_LIMIT = 600000;
  localparam int ITEM_TARGET = 1400;
  localparam int SETTLE      = 50;
  localparam opcode_t OPC_POOL [12] = '{OPC_READ, OPC_WRITE, OPC_LOAD, OPC_STORE,
                                        OPC_ADD, OPC_SUB, OPC_DIV, OPC_MUL,
                                        OPC_BR, OPC_BRNEG, OPC_BRZERO, OPC_HALT};

  logic clk;
  logic rst;

  amstep_chan_if #(.payload_t(item_t))   item_ch ();
  amstep_chan_if #(.payload_t(result_t)) result_ch ();

  accumulator_machine_step #(.MEM_WORDS(MEM_WORDS)) dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  // machine state as the predictor sees it
  int      prog_mem [MEM_WORDS];
  int      loaded_cnt = 0;
  int      pc_q = 0;
  int      acc_q = 0;
  status_t run_q = ST_HALT;

  item_t   pending [$];
  result_t expected_q [$];
  int      err_cnt = 0;
  int unsigned cycle_cnt = 0;
  logic    beat_taken = 1'b0;
  int      gap_left = 0;
  int      stall_left = 0;
  bit      steady = 1'b0;

  function automatic int rand_int(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic bit addr_valid(int a);
    return a >= 0 && a < loaded_cnt;
  endfunction

  function automatic bit fits_word(int v);
    return v >= -WORD_LIMIT && v <= WORD_LIMIT;
  endfunction

  function automatic status_t run_instr(input int din, output bit printed, output int pval,
                                        output bit used);
    int      word;
    int      opc;
    int      addr;
    int      val;
    bit      adv;
    status_t fault;
    printed = 1'b0;
    pval = 0;
    used = 1'b0;
    adv = 1'b1;
    fault = ST_RUN;
    if (run_q != ST_RUN)
      return run_q;
    if (pc_q >= loaded_cnt) begin
      run_q = ST_ADDR;
      return run_q;
    end
    word = prog_mem[pc_q];
    opc = word / DECIMAL_BASE;
    addr = word % DECIMAL_BASE;
    case (opc)
      OPC_READ: begin
        used = 1'b1;
        if (!fits_word(din))
          fault = ST_INRANGE;
        else if (!addr_valid(addr))
          fault = ST_ADDR;
        else
          prog_mem[addr] = din;
      end
      OPC_WRITE: begin
        if (!addr_valid(addr)) begin
          fault = ST_ADDR;
        end else begin
          printed = 1'b1;
          pval = prog_mem[addr];
        end
      end
      OPC_LOAD: begin
        if (!addr_valid(addr))
          fault = ST_ADDR;
        else
          acc_q = prog_mem[addr];
      end
      OPC_STORE: begin
        if (!addr_valid(addr))
          fault = ST_ADDR;
        else
          prog_mem[addr] = acc_q;
      end
      OPC_ADD, OPC_SUB, OPC_MUL: begin
        if (!addr_valid(addr)) begin
          fault = ST_ADDR;
        end else begin
          if (opc == OPC_ADD)
            val = acc_q + prog_mem[addr];
          else if (opc == OPC_SUB)
            val = acc_q - prog_mem[addr];
          else
            val = acc_q * prog_mem[addr];
          if (!fits_word(val))
            fault = ST_OVF;
          else
            acc_q = val;
        end
      end
      OPC_DIV: begin
        if (!addr_valid(addr)) begin
          fault = ST_ADDR;
        end else if (prog_mem[addr] == 0) begin
          fault = ST_DIV0;
        end else begin
          val = acc_q / prog_mem[addr];
          if (!fits_word(val))
            fault = ST_OVF;
          else
            acc_q = val;
        end
      end
      OPC_BR, OPC_BRNEG, OPC_BRZERO: begin
        if (opc == OPC_BR || (opc == OPC_BRNEG && acc_q < 0) ||
            (opc == OPC_BRZERO && acc_q == 0)) begin
          if (!addr_valid(addr)) begin
            fault = ST_ADDR;
          end else begin
            pc_q = addr;
            adv = 1'b0;
          end
        end
      end
      OPC_HALT: run_q = ST_HALT;
      default: ;
    endcase
    if (fault != ST_RUN) begin
      run_q = fault;
      return run_q;
    end
    if (adv)
      pc_q = (pc_q + 1) & 'h7f;
    return run_q;
  endfunction

  function automatic result_t machine_predict(item_t it);
    result_t r;
    int      din;
    bit      printed;
    bit      used;
    int      pval;
    r = '0;
    din = it.data_value;
    printed = 1'b0;
    used = 1'b0;
    pval = 0;
    case (it.operation)
      OP_APPEND: begin
        if (loaded_cnt >= MEM_WORDS) begin
          r.status = ST_FULL;
        end else begin
          prog_mem[loaded_cnt] = din;
          loaded_cnt++;
          r.status = ST_RUN;
        end
      end
      OP_START: begin
        pc_q = 0;
        acc_q = 0;
        run_q = ST_RUN;
        r.status = run_q;
      end
      OP_STEP: r.status = run_instr(din, printed, pval, used);
      default: begin
        loaded_cnt = 0;
        pc_q = 0;
        acc_q = 0;
        run_q = ST_HALT;
        r.status = run_q;
      end
    endcase
    r.program_counter = pc_q[PC_W-1:0];
    r.accumulator_value = word_t'(acc_q);
    r.print_valid = printed;
    r.printed_word = word_t'(pval);
    r.input_used = used;
    return r;
  endfunction

  task automatic push_item(operation_t op, int v);
    item_t it;
    it.operation = op;
    it.data_value = word_t'(v);
    pending.insert(pending.size(), it);
  endtask

  function automatic int encode_word(opcode_t opc, int addr);
    return int'(opc) * DECIMAL_BASE + addr;
  endfunction

  function automatic int data_word();
    int k;
    k = rand_int(0, 99);
    if (k < 40) return rand_int(-12, 12);
    if (k < 70) return rand_int(-99, 99);
    if (k < 88) return rand_int(-WORD_LIMIT, WORD_LIMIT);
    if (k < 94) return (k < 91) ? WORD_LIMIT : -WORD_LIMIT;
    return rand_int(-32768, 32767);
  endfunction

  function automatic int instr_word(int code_len, int n);
    int     k;
    int     addr;
    opcode_t opc;
    k = rand_int(0, 99);
    if (k < 5) return rand_int(-32768, 32767);
    if (k < 9) return rand_int(0, 99) * DECIMAL_BASE + rand_int(0, 99);
    opc = OPC_POOL[rand_int(0, 11)];
    if (opc == OPC_BR || opc == OPC_BRNEG || opc == OPC_BRZERO)
      addr = rand_int(0, code_len - 1);
    else
      addr = rand_int(code_len, n - 1);
    if (n < MEM_WORDS && rand_int(0, 99) < 6)
      addr = rand_int(n, 99);
    return encode_word(opc, addr);
  endfunction

  function automatic int step_data();
    int k;
    k = rand_int(0, 99);
    if (k < 70) return rand_int(-20, 20);
    if (k < 85) return rand_int(-WORD_LIMIT, WORD_LIMIT);
    if (k < 93) return (k < 89) ? WORD_LIMIT + 1 : -WORD_LIMIT - 1;
    return rand_int(-32768, 32767);
  endfunction

  // clear, load a program with a data area at the top, start it and step it, with a restart or an append now and then
  task automatic queue_program(int n, int extra);
    int code_len;
    int steps;
    int k;
    push_item(OP_CLEAR, rand_int(-32768, 32767));
    code_len = rand_int((n + 1) / 2, n - 1);
    for (int i = 0; i < n; i++)
      push_item(OP_APPEND, (i < code_len) ? instr_word(code_len, n) : data_word());
    repeat (extra) push_item(OP_APPEND, data_word());
    push_item(OP_START, rand_int(-32768, 32767));
    steps = (n >= MEM_WORDS) ? rand_int(40, 120) : rand_int(n, 3 * n);
    repeat (steps) begin
      k = rand_int(0, 99);
      if (k < 93)
        push_item(OP_STEP, step_data());
      else if (k < 96)
        push_item(OP_START, rand_int(-32768, 32767));
      else
        push_item(OP_APPEND, data_word());
    end
  endtask

  function automatic int pick_gap();
    int k;
    k = rand_int(0, 99);
    if (steady || k < 60) return 0;
    if (k < 92) return rand_int(1, 3);
    return rand_int(8, 40);
  endfunction

  task automatic check_field(string what, logic [15:0] want_v, logic [15:0] got_v);
    if (got_v !== want_v) begin
      err_cnt++;
      $display("%0t: %s expected %0h got %0h", $time, what, want_v, got_v);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // beat driver
  always @(negedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
    end else if (!item_ch.valid || beat_taken) begin
      if (gap_left > 0) begin
        item_ch.valid <= 1'b0;
        gap_left--;
      end else if (pending.size() != 0) begin
        item_ch.valid <= 1'b1;
        item_ch.data <= pending.pop_front();
        gap_left = pick_gap();
        if (rand_int(0, 199) == 0)
          steady = !steady;
      end else begin
        item_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      result_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      result_ch.ready <= 1'b1;
      if (rand_int(0, 3) == 0)
        stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin : monitor
    result_t want;
    result_t got;
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      beat_taken <= !rst && item_ch.valid && item_ch.ready;
      if (!rst && item_ch.valid && item_ch.ready)
        expected_q.insert(expected_q.size(), machine_predict(item_ch.data));
      if (!rst && result_ch.valid && result_ch.ready) begin
        got = result_ch.data;
        if (expected_q.size() == 0) begin
          err_cnt++;
          $display("%0t: result beat with nothing expected, status %0h", $time, got.status);
        end else begin
          want = expected_q.pop_front();
          check_field("status", want.status, got.status);
          check_field("program_counter", want.program_counter, got.program_counter);
          check_field("accumulator_value", want.accumulator_value, got.accumulator_value);
          check_field("print_valid", want.print_valid, got.print_valid);
          check_field("printed_word", want.printed_word, got.printed_word);
          check_field("input_used", want.input_used, got.input_used);
        end
      end
    end
  end

  initial begin
    int k;
    rst = 1'b1;
    item_ch.valid = 1'b0;
    item_ch.data = '0;
    result_ch.ready = 1'b0;

    // stopped machine, empty memory, then a short program through most opcodes
    push_item(OP_STEP, -32768);
    push_item(OP_START, 32767);
    push_item(OP_STEP, 0);
    push_item(OP_CLEAR, 0);
    push_item(OP_APPEND, encode_word(OPC_READ, 9));
    push_item(OP_APPEND, encode_word(OPC_LOAD, 9));
    push_item(OP_APPEND, encode_word(OPC_MUL, 8));
    push_item(OP_APPEND, encode_word(OPC_DIV, 8));
    push_item(OP_APPEND, encode_word(OPC_WRITE, 9));
    push_item(OP_APPEND, encode_word(OPC_BRNEG, 7));
    push_item(OP_APPEND, encode_word(OPC_HALT, 0));
    push_item(OP_APPEND, -32768);
    push_item(OP_APPEND, -2);
    push_item(OP_APPEND, 32767);
    push_item(OP_START, 0);
    push_item(OP_STEP, -5);
    repeat (10) push_item(OP_STEP, 0);
    push_item(OP_START, 0);
    push_item(OP_STEP, WORD_LIMIT + 1);

    while (pending.size() < ITEM_TARGET) begin
      k = rand_int(0, 99);
      if (k < 6)
        queue_program(MEM_WORDS, rand_int(1, 3));
      else if (k < 92)
        queue_program(rand_int(2, 16), 0);
      else
        repeat (rand_int(1, 6)) push_item(operation_t'(rand_int(0, 3)), rand_int(-32768, 32767));
    end

    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (pending.size() != 0 || item_ch.valid) @(negedge clk);
    while (expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (err_cnt == 0 && expected_q.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
